// ===== hw/rtl/xcfe_pkg.sv =====
// shared types and constants for the xor-checked frame encoder
`timescale 1ns / 1ps

package xcfe_pkg;

  // frame framing bytes
  localparam logic [7:0] HDR0  = 8'hA5;
  localparam logic [7:0] HDR1  = 8'h5A;
  localparam logic [7:0] TAIL0 = 8'h0D;
  localparam logic [7:0] TAIL1 = 8'h0A;

  // payload length limit and fixed frame overhead
  localparam logic [15:0] MAX_PAYLOAD    = 16'd65527;
  localparam logic [15:0] FRAME_OVERHEAD = 16'd8;

  // command queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // request type codes on the input channel
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  typedef enum logic {
    CMD_HEADER,
    CMD_PAYLOAD
  } cmd_kind_t;

  // one classified request handed from front to back
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  byte_val;
    logic [7:0]  len_hi;
    logic [7:0]  len_lo;
    logic [7:0]  chk;
    logic        trailer;
  } cmd_t;

  // queue status seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // output byte sequencer steps
  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_H0,
    SEQ_H1,
    SEQ_LHI,
    SEQ_LLO,
    SEQ_OP,
    SEQ_DATA,
    SEQ_CHK,
    SEQ_T0,
    SEQ_T1
  } seq_state_t;

endpackage

// ===== hw/rtl/xcfe_front.sv =====
// front end: accepts requests, tracks the open frame and classifies commands
`timescale 1ns / 1ps

module xcfe_front
  import xcfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_opcode,
  input  logic [15:0] in_payload_len,
  input  logic [7:0]  in_data_byte,
  input  q_stat_t     q_stat,
  output logic        push,
  output cmd_t        push_cmd
);

  logic        frame_open_r, frame_open_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  running_xor_r, running_xor_nxt;

  logic        accept;
  logic [15:0] len_sat;
  logic [15:0] total;
  logic [7:0]  hdr_chk;
  logic [7:0]  pay_chk;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // header fields of a start request
  assign len_sat = (in_payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : in_payload_len;
  assign total   = len_sat + FRAME_OVERHEAD;
  assign hdr_chk = total[15:8] ^ total[7:0] ^ in_opcode;
  assign pay_chk = running_xor_r ^ in_data_byte;

  // classify the request and update frame tracking
  always_comb begin
    frame_open_nxt  = frame_open_r;
    bytes_left_nxt  = bytes_left_r;
    running_xor_nxt = running_xor_r;
    push            = 1'b0;
    push_cmd        = '0;
    if (accept) begin
      if (in_req_type == REQ_START) begin
        push              = 1'b1;
        push_cmd.kind     = CMD_HEADER;
        push_cmd.byte_val = in_opcode;
        push_cmd.len_hi   = total[15:8];
        push_cmd.len_lo   = total[7:0];
        push_cmd.chk      = hdr_chk;
        push_cmd.trailer  = (len_sat == 16'd0);
        frame_open_nxt    = (len_sat != 16'd0);
        bytes_left_nxt    = len_sat;
        running_xor_nxt   = (len_sat == 16'd0) ? 8'd0 : hdr_chk;
      end else if (frame_open_r) begin
        push              = 1'b1;
        push_cmd.kind     = CMD_PAYLOAD;
        push_cmd.byte_val = in_data_byte;
        push_cmd.chk      = pay_chk;
        push_cmd.trailer  = (bytes_left_r == 16'd1);
        bytes_left_nxt    = bytes_left_r - 16'd1;
        if (bytes_left_r == 16'd1) begin
          frame_open_nxt  = 1'b0;
          running_xor_nxt = 8'd0;
        end else begin
          running_xor_nxt = pay_chk;
        end
      end
    end
  end

  // frame tracking registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r  <= 1'b0;
      bytes_left_r  <= 16'd0;
      running_xor_r <= 8'd0;
    end else begin
      frame_open_r  <= frame_open_nxt;
      bytes_left_r  <= bytes_left_nxt;
      running_xor_r <= running_xor_nxt;
    end
  end

  // an open frame always expects at least one more byte
  a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    frame_open_r |-> (bytes_left_r != 16'd0))
    else $error("open frame with no bytes left");

  // nothing is pushed without an accepted request
  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> accept)
    else $error("push without accepted request");

  // a closed frame keeps a cleared checksum
  a_closed_xor_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !frame_open_r |-> (running_xor_r == 8'd0))
    else $error("checksum not cleared on closed frame");

endmodule

// ===== hw/rtl/xcfe_queue.sv =====
// short command queue between front and back ends
`timescale 1ns / 1ps

module xcfe_queue
  import xcfe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head_cmd,
  output logic    head_valid,
  output q_stat_t q_stat
);

  cmd_t              slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head_cmd     = slots_r[rd_ptr_r];
  assign head_valid   = (count_r != '0);
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == QCNT_W'(QDEPTH));

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != QCNT_W'(QDEPTH)))
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

// ===== hw/rtl/xcfe_back.sv =====
// back end: expands queued commands into frame bytes, one per cycle unless out_ready stalls
`timescale 1ns / 1ps

module xcfe_back
  import xcfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head_cmd,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_frame_end
);

  seq_state_t st_r, st_nxt;
  seq_state_t cur;
  seq_state_t step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_frame_end_r;
  logic       fire;
  logic       last;
  logic [7:0] byte_val;
  logic       end_val;

  assign fire = head_valid && (!out_valid_r || out_ready);

  // step select and byte generation
  always_comb begin
    if (st_r == SEQ_IDLE) begin
      cur = (head_cmd.kind == CMD_HEADER) ? SEQ_H0 : SEQ_DATA;
    end else begin
      cur = st_r;
    end
    byte_val = 8'd0;
    end_val  = 1'b0;
    last     = 1'b0;
    step_nxt = SEQ_IDLE;
    case (cur)
      SEQ_H0: begin
        byte_val = HDR0;
        step_nxt = SEQ_H1;
      end
      SEQ_H1: begin
        byte_val = HDR1;
        step_nxt = SEQ_LHI;
      end
      SEQ_LHI: begin
        byte_val = head_cmd.len_hi;
        step_nxt = SEQ_LLO;
      end
      SEQ_LLO: begin
        byte_val = head_cmd.len_lo;
        step_nxt = SEQ_OP;
      end
      SEQ_OP, SEQ_DATA: begin
        byte_val = head_cmd.byte_val;
        if (head_cmd.trailer) begin
          step_nxt = SEQ_CHK;
        end else begin
          last = 1'b1;
        end
      end
      SEQ_CHK: begin
        byte_val = head_cmd.chk;
        step_nxt = SEQ_T0;
      end
      SEQ_T0: begin
        byte_val = TAIL0;
        step_nxt = SEQ_T1;
      end
      SEQ_T1: begin
        byte_val = TAIL1;
        end_val  = 1'b1;
        last     = 1'b1;
      end
      default: begin
        step_nxt = SEQ_IDLE;
      end
    endcase
    st_nxt        = fire ? step_nxt : st_r;
    pop           = fire && last;
    out_valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // sequencer state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= SEQ_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r      <= byte_val;
      out_frame_end_r <= end_val;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_frame_end = out_frame_end_r;

  a_end_is_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_end_r) |-> (out_byte_r == TAIL1))
    else $error("frame end not on closing byte");

  a_mid_cmd_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != SEQ_IDLE) |-> head_valid)
    else $error("sequencer mid-command with empty queue");

  a_pop_ends_step: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (st_r == SEQ_IDLE))
    else $error("sequencer not idle after pop");

endmodule

// ===== hw/rtl/xor_checked_frame_encoder_top.sv =====
// Frame encoder with XOR checksum. A start request (opcode, payload length)
// produces the header A5 5A, the 16-bit total length (payload + 8, high byte
// first, payload length saturated at 65527) and the opcode; each payload
// request produces one byte; the last payload byte (or a zero-length start)
// is followed by the XOR of length bytes, opcode and payload, then 0D 0A with
// frame_end on the 0A. Payload requests with no open frame are taken and
// dropped; a start abandons an open frame. The front end accepts one request
// per cycle while its 4-entry command queue has room; the back end emits one
// byte per cycle unless out_ready stalls it, so payload streams at one byte
// per cycle; a start makes 5 output bytes (8 for an empty frame), a closing
// payload byte 4. Requests pass the queue and then the output register.
`timescale 1ns / 1ps

module xor_checked_frame_encoder_top
  import xcfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_opcode,
  input  logic [15:0] in_payload_len,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_frame_end
);

  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  cmd_t    head_cmd;
  logic    head_valid;
  q_stat_t q_stat;

  // request classification and frame tracking
  xcfe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_opcode      (in_opcode),
    .in_payload_len (in_payload_len),
    .in_data_byte   (in_data_byte),
    .q_stat         (q_stat),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  // decoupling command queue
  xcfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .q_stat     (q_stat)
  );

  // byte sequencer and output register
  xcfe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_cmd      (head_cmd),
    .head_valid    (head_valid),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end)
  );

endmodule
